// ===== hdl/pew_pkg.sv =====
// shared constants and types for the periodic event wakeup block
package pew_pkg;

    localparam int CHANNELS  = 4;
    localparam int TASKS     = 64;
    localparam int REG_COUNT = 4;
    localparam int ACTIVE_CH = (CHANNELS < REG_COUNT) ? CHANNELS : REG_COUNT;

    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int CH_W     = 2;
    localparam int TASK_W   = 6;
    localparam int MASK_W   = 64;
    localparam int FIRED_W  = 4;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_WAIT = 1'b1;

    localparam logic [MASK_W-1:0] TASK_MASK =
        (TASKS >= MASK_W) ? {MASK_W{1'b1}} : ((MASK_W'(1) << TASKS) - MASK_W'(1));

    localparam logic [PERIOD_W-1:0] PERIOD_RESET [REG_COUNT] = '{
        PERIOD_W'(100), PERIOD_W'(200), PERIOD_W'(500), PERIOD_W'(50)
    };

    typedef struct packed {
        logic              go;
        logic              tick;
        logic              wait_sel;
        logic [TIME_W-1:0] now;
        logic [MASK_W-1:0] task_bit;
    } t_chan_cmd;

    typedef struct packed {
        logic [MASK_W-1:0]  woken;
        logic [FIRED_W-1:0] fired;
        logic               resched;
    } t_result;

endpackage

// ===== hdl/pew_channel.sv =====
// one channel: period register, next-match time and waiter set
module pew_channel (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [pew_pkg::PERIOD_W-1:0] i_reset_period,
    input  logic                         i_cfg_we,
    input  logic [pew_pkg::PERIOD_W-1:0] i_cfg_data,
    input  pew_pkg::t_chan_cmd           i_cmd,
    output logic                         o_fire,
    output logic [pew_pkg::MASK_W-1:0]   o_waiters
);
    import pew_pkg::*;

    logic [PERIOD_W-1:0] r_period, n_period;
    logic [TIME_W-1:0]   r_next, n_next;
    logic [MASK_W-1:0]   r_waiters, n_waiters;
    logic                fire;

    assign fire = i_cmd.go && i_cmd.tick && (i_cmd.now == r_next);

    always_comb begin
        n_period  = i_cfg_we ? i_cfg_data : r_period;
        n_next    = r_next;
        n_waiters = r_waiters;
        if (fire) begin
            n_next    = r_next + TIME_W'(r_period);
            n_waiters = '0;
        end else if (i_cmd.go && i_cmd.wait_sel) begin
            n_waiters = r_waiters | i_cmd.task_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= i_reset_period;
            r_next    <= TIME_W'(i_reset_period);
            r_waiters <= '0;
        end else begin
            r_period  <= n_period;
            r_next    <= n_next;
            r_waiters <= n_waiters;
        end
    end

    assign o_fire    = fire;
    assign o_waiters = r_waiters;

endmodule

// ===== hdl/pew_out.sv =====
// result register toward the output channel
module pew_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  pew_pkg::t_result i_result,
    input  logic             i_out_stall,
    output logic             o_free,
    output logic             o_out_valid,
    output pew_pkg::t_result o_result
);
    import pew_pkg::*;

    logic    r_valid, n_valid;
    t_result r_result;

    assign o_free = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

// ===== hdl/periodic_event_wakeup.sv =====
// periodic event wakeup: a word goes through the input register, then the result register
// throughput one word per cycle unless the output stalls; the two registers split the path
// the per-channel match compare and waiter update sit between those two registers
// synchronous active-low reset: periods and next-match times take their defaults,
// waiter sets clear, both registers empty
module periodic_event_wakeup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [pew_pkg::TIME_W-1:0]    i_now_ms,
    input  logic [pew_pkg::CH_W-1:0]      i_channel,
    input  logic [pew_pkg::TASK_W-1:0]    i_task_id,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pew_pkg::MASK_W-1:0]    o_woken_tasks,
    output logic [pew_pkg::FIRED_W-1:0]   o_fired_channels,
    output logic                          o_reschedule,
    input  logic                          i_cfg_we,
    input  logic [pew_pkg::CH_W-1:0]      i_cfg_index,
    input  logic [pew_pkg::PERIOD_W-1:0]  i_cfg_data
);
    import pew_pkg::*;

    logic              r_in_valid, n_in_valid;
    logic              r_action;
    logic [TIME_W-1:0] r_now;
    logic [CH_W-1:0]   r_channel;
    logic [TASK_W-1:0] r_task;

    logic              out_free;
    logic              go;
    logic              task_ok;
    logic [MASK_W-1:0] task_bit;
    t_result           result;
    t_result           out_result;

    logic              fire    [ACTIVE_CH];
    logic [MASK_W-1:0] waiters [ACTIVE_CH];

    assign go         = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_in_valid && !o_in_stall) begin
            n_in_valid = 1'b1;
        end else if (go) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_action  <= i_action;
            r_now     <= i_now_ms;
            r_channel <= i_channel;
            r_task    <= i_task_id;
        end
    end

    // out-of-range task ids drop to an empty mask
    assign task_ok  = ({1'b0, r_task} < (TASK_W + 1)'(TASKS));
    assign task_bit = task_ok ? ((MASK_W'(1) << r_task) & TASK_MASK) : '0;

    for (genvar c = 0; c < ACTIVE_CH; c++) begin : g_chan
        t_chan_cmd cmd;
        always_comb begin
            cmd.go       = go;
            cmd.tick     = (r_action == ACT_TICK);
            cmd.wait_sel = (r_action == ACT_WAIT) && (r_channel == CH_W'(c));
            cmd.now      = r_now;
            cmd.task_bit = task_bit;
        end

        pew_channel u_chan (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_reset_period (PERIOD_RESET[c]),
            .i_cfg_we       (i_cfg_we && (i_cfg_index == CH_W'(c))),
            .i_cfg_data     (i_cfg_data),
            .i_cmd          (cmd),
            .o_fire         (fire[c]),
            .o_waiters      (waiters[c])
        );
    end

    always_comb begin
        result.woken = '0;
        result.fired = '0;
        for (int c = 0; c < ACTIVE_CH; c++) begin
            if (fire[c]) begin
                result.woken    = result.woken | waiters[c];
                result.fired[c] = 1'b1;
            end
        end
        result.resched = (result.woken != '0);
    end

    pew_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (go),
        .i_result    (result),
        .i_out_stall (i_out_stall),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_woken_tasks    = out_result.woken;
    assign o_fired_channels = out_result.fired;
    assign o_reschedule     = out_result.resched;

    // woken tasks only come from a channel that fired
    a_woken_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reschedule |-> o_fired_channels != '0)
        else $error("tasks woken with no channel fired");

    // a held word is still there in the next cycle
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_woken_tasks))
        else $error("stalled result lost");

    // input only stalls while a word sits in the input register and the output is blocked
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

endmodule
